>>> sv/ocam_pkg.sv
`timescale 1ns / 1ps

package ocam_pkg;

  // Sizing
  localparam int WORD_BITS    = 32;   // width of the target coordinates
  localparam int CORDIC_STEPS = 16;   // CORDIC rotations, at most 24

  localparam int MOVE_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int RAD_W     = 24;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 48;     // three motion fields
  localparam int IN_USER_W  = 2;      // two button flags
  localparam int OUT_DATA_W = 6 * OUT_W;

  localparam int AZ_W    = 19;        // azimuth in [0, 2pi)
  localparam int POL_W   = 18;        // polar in [0.01, pi-0.01]
  localparam int ANG_W   = 21;        // signed angle into the CORDIC
  localparam int TRIG_W  = 19;        // sin/cos and their products, Q16.16
  localparam int CXY_W   = 34;        // CORDIC x/y, Q2.30
  localparam int CZ_W    = 36;        // CORDIC residual angle, Q2.30
  localparam int ACC_W   = 34;        // pan direction sums
  localparam int CALC_W  = 36;        // angle and radius update sums
  localparam int MA_W    = 35;        // multiplier operand A
  localparam int MB_W    = 25;        // multiplier operand B
  localparam int PROD_W  = MA_W + MB_W;
  localparam int RND_W   = PROD_W - 16;
  localparam int SUM_W   = ((WORD_BITS > RND_W) ? WORD_BITS : RND_W) + 1;
  localparam int REM_W   = 33;        // offset azimuth sum, always positive
  localparam int CNT_W   = 5;

  // Fixed-point constants, Q16.16 unless noted
  localparam logic [ANG_W-1:0] FX_PI       = ANG_W'(205887);
  localparam logic [ANG_W-1:0] FX_TWO_PI   = ANG_W'(411775);
  localparam logic [ANG_W-1:0] FX_HALF_PI  = ANG_W'(102944);
  localparam logic [POL_W-1:0] FX_POL_MIN  = POL_W'(655);
  localparam logic [POL_W-1:0] FX_POL_MAX  = POL_W'(205887 - 655);
  localparam logic [REM_W-1:0] REM_MODULUS = REM_W'(411775);
  localparam logic [CALC_W-1:0] MOD_OFFSET = CALC_W'(64'd411775 * 64'd8192);
  localparam logic [CXY_W-1:0] CORDIC_GAIN = CXY_W'(652032874);   // Q2.30
  // 2^42 / 2pi: (sum >> 10) * AZ_RECIP >> 32 underestimates the wrap count by
  // at most one
  localparam logic [MB_W-1:0]  AZ_RECIP    = MB_W'((64'd1 << 42) / 64'd411775);

  localparam logic [GAIN_W-1:0] ORBIT_GAIN_RST = GAIN_W'(328);
  localparam logic [GAIN_W-1:0] PAN_GAIN_RST   = GAIN_W'(197);
  localparam logic [GAIN_W-1:0] ZOOM_GAIN_RST  = GAIN_W'(66);
  localparam logic [RAD_W-1:0]  RADIUS_MIN_RST = RAD_W'(32768);
  localparam logic [RAD_W-1:0]  RADIUS_MAX_RST = RAD_W'(3276800);
  localparam logic [RAD_W-1:0]  RADIUS_RST     = RAD_W'(196608);

  // Microprogram layout: pan, zoom, eye
  localparam logic [CNT_W-1:0] UC_PAN_FIRST  = CNT_W'(0);
  localparam logic [CNT_W-1:0] UC_PAN_LAST   = CNT_W'(11);
  localparam logic [CNT_W-1:0] UC_ZOOM_FIRST = CNT_W'(12);
  localparam logic [CNT_W-1:0] UC_ZOOM_LAST  = CNT_W'(13);
  localparam logic [CNT_W-1:0] UC_EYE_FIRST  = CNT_W'(14);
  localparam logic [CNT_W-1:0] UC_EYE_LAST   = CNT_W'(19);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORBIT_GAIN,
    REG_PAN_GAIN,
    REG_ZOOM_GAIN,
    REG_RADIUS_MIN,
    REG_RADIUS_MAX
  } cfg_reg_t;

  // Operand pair for the shared multiplier
  typedef enum logic [4:0] {
    MS_NONE, MS_DX_OG, MS_DY_OG, MS_R_PG, MS_CT_CP, MS_CT_SP, MS_DX_SP,
    MS_DY_CTCP, MS_DY_ST, MS_DX_CP, MS_DY_CTSP, MS_MX_SC, MS_MY_SC,
    MS_MZ_SC, MS_WH_ZG, MS_ST_CP, MS_ST_SP, MS_R_CT, MS_R_STCP, MS_R_STSP,
    MS_REM_RCP, MS_QT_MOD
  } mul_sel_t;

  // Destination of the registered product
  typedef enum logic [4:0] {
    WB_NONE, WB_AZ_PREP, WB_POL, WB_RAD, WB_SCALE, WB_CTCP, WB_CTSP,
    WB_MX_LD, WB_MX_SUB, WB_MY_LD, WB_MZ_NEG, WB_MZ_SUB,
    WB_TX, WB_TY, WB_TZ, WB_STCP, WB_STSP, WB_EX, WB_EY, WB_EZ
  } wb_sel_t;

  typedef enum logic [2:0] {
    SQ_NONE, SQ_AZ_SET, SQ_COR_INIT, SQ_COR_STEP, SQ_COR_END
  } seq_op_t;

  typedef struct packed {
    mul_sel_t mul;
    wb_sel_t  wb;
  } uop_t;

  typedef struct packed {
    logic             load;
    logic             out_load;
    seq_op_t          seq;
    logic [CNT_W-1:0] idx;
    logic             sel_pol;
    mul_sel_t         mul;
    wb_sel_t          wb;
  } ocam_cmd_t;

  typedef struct packed {
    logic left;
    logic pan_en;
    logic zoom_en;
  } ocam_stat_t;

  // atan(2^-i) in Q2.30, rounded to nearest
  function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837830;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Multiply/writeback schedule; writeback of step n overlaps multiply of n+1
  function automatic uop_t ucode(input logic [CNT_W-1:0] step);
    uop_t u;
    unique case (step)
      5'd0:  u = '{MS_R_PG,    WB_NONE};
      5'd1:  u = '{MS_CT_CP,   WB_SCALE};
      5'd2:  u = '{MS_CT_SP,   WB_CTCP};
      5'd3:  u = '{MS_DX_SP,   WB_CTSP};
      5'd4:  u = '{MS_DY_CTCP, WB_MX_LD};
      5'd5:  u = '{MS_DY_ST,   WB_MX_SUB};
      5'd6:  u = '{MS_DX_CP,   WB_MY_LD};
      5'd7:  u = '{MS_DY_CTSP, WB_MZ_NEG};
      5'd8:  u = '{MS_MX_SC,   WB_MZ_SUB};
      5'd9:  u = '{MS_MY_SC,   WB_TX};
      5'd10: u = '{MS_MZ_SC,   WB_TY};
      5'd11: u = '{MS_NONE,    WB_TZ};
      5'd12: u = '{MS_WH_ZG,   WB_NONE};
      5'd13: u = '{MS_NONE,    WB_RAD};
      5'd14: u = '{MS_ST_CP,   WB_NONE};
      5'd15: u = '{MS_ST_SP,   WB_STCP};
      5'd16: u = '{MS_R_CT,    WB_STSP};
      5'd17: u = '{MS_R_STCP,  WB_EY};
      5'd18: u = '{MS_R_STSP,  WB_EX};
      5'd19: u = '{MS_NONE,    WB_EZ};
      default: u = '{MS_NONE,  WB_NONE};
    endcase
    return u;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_word(
      input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(WORD_BITS-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[WORD_BITS-1:0];
    else if (v < lo) return lo[WORD_BITS-1:0];
    else return v[WORD_BITS-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(
      input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(OUT_W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[OUT_W-1:0];
    else if (v < lo) return lo[OUT_W-1:0];
    else return v[OUT_W-1:0];
  endfunction

endpackage

>>> sv/orbit_camera_pose_update.sv
`timescale 1ns / 1ps

// Channel   Ports                         Fields (lowest bit first)
// in        in_tvalid/in_tready           tdata: move_x, move_y, wheel_move
//                                         tuser: left_held, right_held
// out       out_tvalid/out_tready         tdata: eye_x, eye_y, eye_z,
//                                                aim_x, aim_y, aim_z
// cfg       cfg_we/cfg_index/cfg_wdata    orbit_gain, pan_gain, zoom_gain,
//                                         radius_min, radius_max
//
// A request with no buttons or wheel runs the CORDIC on azimuth and polar,
// then the eye products; an orbit adds the azimuth wrap (reciprocal estimate
// and one correction), a pan the pan products, a zoom the radius update. The
// next request is taken only once the result is loaded and the FSM is idle.
// The iterative CORDIC, run once per angle, and the single shared multiplier
// set the latency. Synchronous active-low reset restores pose and configuration.
// A finished result sits in the output register; the next request is taken
// meanwhile and only waits at its own end if the previous result is unread.

module orbit_camera_pose_update (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ocam_pkg::IN_DATA_W-1:0]  in_tdata,   // move_x, move_y, wheel_move
  input  logic [ocam_pkg::IN_USER_W-1:0]  in_tuser,   // left_held, right_held
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ocam_pkg::OUT_DATA_W-1:0] out_tdata,  // eye_x..z, aim_x..z
  input  logic                            cfg_we,
  input  logic [ocam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ocam_pkg::RAD_W-1:0]      cfg_wdata
);
  import ocam_pkg::*;

  ocam_cmd_t  cmd;
  ocam_stat_t stat;

  ocam_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ocam_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_tdata),
    .in_user   (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_tdata)
  );

endmodule

>>> sv/ocam_dp.sv
`timescale 1ns / 1ps

module ocam_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ocam_pkg::ocam_cmd_t           cmd,
  output ocam_pkg::ocam_stat_t          stat,
  input  logic [ocam_pkg::IN_DATA_W-1:0]  in_data,
  input  logic [ocam_pkg::IN_USER_W-1:0]  in_user,
  input  logic                          cfg_we,
  input  logic [ocam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ocam_pkg::RAD_W-1:0]      cfg_wdata,
  output logic [ocam_pkg::OUT_DATA_W-1:0] out_data
);
  import ocam_pkg::*;

  // Request fields
  logic signed [MOVE_W-1:0] dx_r, dy_r, wh_r;
  logic                     left_r, right_r;

  // Configuration
  logic [GAIN_W-1:0] og_r, pg_r, zg_r;
  logic [RAD_W-1:0]  rmin_r, rmax_r;

  // Pose state
  logic [RAD_W-1:0]            r_r;
  logic [POL_W-1:0]            pol_r;
  logic [AZ_W-1:0]             az_r;
  logic signed [WORD_BITS-1:0] tx_r, ty_r, tz_r;

  // Working registers
  logic [REM_W-1:0]         rem_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [CXY_W-1:0]  cx_r, cy_r;
  logic signed [CZ_W-1:0]   cz_r;
  logic                     cneg_r;
  logic signed [TRIG_W-1:0] sp_r, cp_r, st_r, ct_r;
  logic signed [TRIG_W-1:0] ctcp_r, ctsp_r, stcp_r, stsp_r;
  logic signed [MB_W-1:0]   scale_r;
  logic signed [ACC_W-1:0]  mx_r, my_r, mz_r;
  logic signed [OUT_W-1:0]  ex_r, ey_r, ez_r;
  logic [OUT_DATA_W-1:0]    out_r;

  assign stat.left    = left_r;
  assign stat.pan_en  = right_r && (dx_r != '0 || dy_r != '0);
  assign stat.zoom_en = (wh_r != '0);
  assign out_data     = out_r;

  // Shared multiplier operand select
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [PROD_W-1:0] prod_nxt;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mul)
      MS_DX_OG:   begin ma = MA_W'(dx_r);   mb = MB_W'({1'b0, og_r}); end
      MS_DY_OG:   begin ma = MA_W'(dy_r);   mb = MB_W'({1'b0, og_r}); end
      MS_R_PG:    begin ma = MA_W'({1'b0, r_r}); mb = MB_W'({1'b0, pg_r}); end
      MS_CT_CP:   begin ma = MA_W'(ct_r);   mb = MB_W'(cp_r); end
      MS_CT_SP:   begin ma = MA_W'(ct_r);   mb = MB_W'(sp_r); end
      MS_DX_SP:   begin ma = MA_W'(dx_r);   mb = MB_W'(sp_r); end
      MS_DY_CTCP: begin ma = MA_W'(dy_r);   mb = MB_W'(ctcp_r); end
      MS_DY_ST:   begin ma = MA_W'(dy_r);   mb = MB_W'(st_r); end
      MS_DX_CP:   begin ma = MA_W'(dx_r);   mb = MB_W'(cp_r); end
      MS_DY_CTSP: begin ma = MA_W'(dy_r);   mb = MB_W'(ctsp_r); end
      MS_MX_SC:   begin ma = MA_W'(mx_r);   mb = scale_r; end
      MS_MY_SC:   begin ma = MA_W'(my_r);   mb = scale_r; end
      MS_MZ_SC:   begin ma = MA_W'(mz_r);   mb = scale_r; end
      MS_WH_ZG:   begin ma = MA_W'(wh_r);   mb = MB_W'({1'b0, zg_r}); end
      MS_ST_CP:   begin ma = MA_W'(st_r);   mb = MB_W'(cp_r); end
      MS_ST_SP:   begin ma = MA_W'(st_r);   mb = MB_W'(sp_r); end
      MS_R_CT:    begin ma = MA_W'({1'b0, r_r}); mb = MB_W'(ct_r); end
      MS_R_STCP:  begin ma = MA_W'({1'b0, r_r}); mb = MB_W'(stcp_r); end
      MS_R_STSP:  begin ma = MA_W'({1'b0, r_r}); mb = MB_W'(stsp_r); end
      // wrap count estimate, then wrap count times 2pi
      MS_REM_RCP: begin ma = MA_W'(rem_r[REM_W-1:10]); mb = AZ_RECIP; end
      MS_QT_MOD:  begin ma = MA_W'(prod_r[PROD_W-1:32]); mb = MB_W'(REM_MODULUS); end
      default:    begin ma = '0; mb = '0; end
    endcase
    prod_nxt = ma * mb;
  end

  // Round-half-up of the product to Q16.16
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [RND_W-1:0]  rnd_q;
  assign prod_rnd = prod_r + signed'(PROD_W'(32768));
  assign rnd_q    = prod_rnd[PROD_W-1:16];

  // Angle and radius update sums
  logic signed [CALC_W-1:0] az_sum, pol_sum, rad_sum;
  logic [POL_W-1:0]         pol_clamped;
  logic [RAD_W-1:0]         rad_clamped;

  assign az_sum  = signed'(CALC_W'(az_r)) + CALC_W'(prod_r) + signed'(MOD_OFFSET);
  assign pol_sum = signed'(CALC_W'(pol_r)) - CALC_W'(prod_r);
  assign rad_sum = signed'(CALC_W'(r_r)) - CALC_W'(prod_r);

  always_comb begin
    if (pol_sum < signed'(CALC_W'(FX_POL_MIN))) pol_clamped = FX_POL_MIN;
    else if (pol_sum > signed'(CALC_W'(FX_POL_MAX))) pol_clamped = FX_POL_MAX;
    else pol_clamped = pol_sum[POL_W-1:0];
  end

  // Raise to min first, then cap at max: max wins when bounds cross
  always_comb begin
    logic signed [CALC_W-1:0] t;
    t = rad_sum;
    if (t < signed'(CALC_W'(rmin_r))) t = signed'(CALC_W'(rmin_r));
    if (t > signed'(CALC_W'(rmax_r))) t = signed'(CALC_W'(rmax_r));
    rad_clamped = t[RAD_W-1:0];
  end

  // Azimuth wrap: remove the estimated multiple of 2pi, then at most one more
  logic [REM_W-1:0] rem_sub;
  logic [AZ_W-1:0]  az_wrapped;

  assign rem_sub = rem_r - prod_r[REM_W-1:0];

  always_comb begin
    if (rem_sub >= REM_MODULUS) az_wrapped = AZ_W'(rem_sub - REM_MODULUS);
    else az_wrapped = rem_sub[AZ_W-1:0];
  end

  // CORDIC angle folding into [-pi/2, pi/2]
  logic signed [ANG_W-1:0] ang_in, ang_w, ang_f;
  logic                    ang_neg;

  always_comb begin
    ang_in  = cmd.sel_pol ? signed'(ANG_W'(pol_r)) : signed'(ANG_W'(az_r));
    ang_w   = ang_in;
    ang_neg = 1'b0;
    if (ang_w > signed'(FX_PI)) ang_w = ang_w - signed'(FX_TWO_PI);
    if (ang_w < -signed'(FX_PI)) ang_w = ang_w + signed'(FX_TWO_PI);
    ang_f = ang_w;
    if (ang_w > signed'(FX_HALF_PI)) begin
      ang_f   = ang_w - signed'(FX_PI);
      ang_neg = 1'b1;
    end else if (ang_w < -signed'(FX_HALF_PI)) begin
      ang_f   = ang_w + signed'(FX_PI);
      ang_neg = 1'b1;
    end
  end

  // CORDIC rotation step and final rounding
  logic signed [CZ_W-1:0]   atan_v;
  logic signed [CXY_W-1:0]  cx_sh, cy_sh;
  logic signed [CXY_W-1:0]  cx_rnd, cy_rnd;
  logic signed [TRIG_W-1:0] cos_q, sin_q;

  assign atan_v = signed'(CZ_W'(atan_q30(cmd.idx)));
  assign cx_sh  = cx_r >>> cmd.idx;
  assign cy_sh  = cy_r >>> cmd.idx;
  assign cx_rnd = cx_r + signed'(CXY_W'(8192));
  assign cy_rnd = cy_r + signed'(CXY_W'(8192));

  always_comb begin
    cos_q = TRIG_W'(cx_rnd[CXY_W-1:14]);
    sin_q = TRIG_W'(cy_rnd[CXY_W-1:14]);
    if (cneg_r) begin
      cos_q = -cos_q;
      sin_q = -sin_q;
    end
  end

  // Configuration and pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      og_r   <= ORBIT_GAIN_RST;
      pg_r   <= PAN_GAIN_RST;
      zg_r   <= ZOOM_GAIN_RST;
      rmin_r <= RADIUS_MIN_RST;
      rmax_r <= RADIUS_MAX_RST;
      r_r    <= RADIUS_RST;
      pol_r  <= POL_W'(FX_HALF_PI);
      az_r   <= '0;
      tx_r   <= '0;
      ty_r   <= '0;
      tz_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ORBIT_GAIN: og_r   <= cfg_wdata[GAIN_W-1:0];
          REG_PAN_GAIN:   pg_r   <= cfg_wdata[GAIN_W-1:0];
          REG_ZOOM_GAIN:  zg_r   <= cfg_wdata[GAIN_W-1:0];
          REG_RADIUS_MIN: rmin_r <= cfg_wdata;
          REG_RADIUS_MAX: rmax_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.seq == SQ_AZ_SET) az_r <= az_wrapped;
      unique case (cmd.wb)
        WB_POL: pol_r <= pol_clamped;
        WB_RAD: r_r   <= rad_clamped;
        WB_TX:  tx_r  <= sat_word(SUM_W'(tx_r) + SUM_W'(rnd_q));
        WB_TY:  ty_r  <= sat_word(SUM_W'(ty_r) + SUM_W'(rnd_q));
        WB_TZ:  tz_r  <= sat_word(SUM_W'(tz_r) + SUM_W'(rnd_q));
        default: ;
      endcase
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r    <= signed'(in_data[15:0]);
      dy_r    <= signed'(in_data[31:16]);
      wh_r    <= signed'(in_data[47:32]);
      left_r  <= in_user[0];
      right_r <= in_user[1];
    end

    prod_r <= prod_nxt;

    unique case (cmd.wb)
      WB_AZ_PREP: rem_r   <= az_sum[REM_W-1:0];
      WB_SCALE:   scale_r <= MB_W'(rnd_q);
      WB_CTCP:    ctcp_r  <= TRIG_W'(rnd_q);
      WB_CTSP:    ctsp_r  <= TRIG_W'(rnd_q);
      WB_STCP:    stcp_r  <= TRIG_W'(rnd_q);
      WB_STSP:    stsp_r  <= TRIG_W'(rnd_q);
      WB_MX_LD:   mx_r    <= ACC_W'(prod_r);
      WB_MX_SUB:  mx_r    <= mx_r - ACC_W'(prod_r);
      WB_MY_LD:   my_r    <= ACC_W'(prod_r);
      WB_MZ_NEG:  mz_r    <= -ACC_W'(prod_r);
      WB_MZ_SUB:  mz_r    <= mz_r - ACC_W'(prod_r);
      WB_EX:      ex_r    <= sat_out(SUM_W'(tx_r) + SUM_W'(rnd_q));
      WB_EY:      ey_r    <= sat_out(SUM_W'(ty_r) + SUM_W'(rnd_q));
      WB_EZ:      ez_r    <= sat_out(SUM_W'(tz_r) + SUM_W'(rnd_q));
      default: ;
    endcase

    unique case (cmd.seq)
      SQ_COR_INIT: begin
        cx_r   <= CORDIC_GAIN;
        cy_r   <= '0;
        cz_r   <= CZ_W'(ang_f) <<< 14;
        cneg_r <= ang_neg;
      end
      SQ_COR_STEP: begin
        if (cz_r >= 0) begin
          cx_r <= cx_r - cy_sh;
          cy_r <= cy_r + cx_sh;
          cz_r <= cz_r - atan_v;
        end else begin
          cx_r <= cx_r + cy_sh;
          cy_r <= cy_r - cx_sh;
          cz_r <= cz_r + atan_v;
        end
      end
      SQ_COR_END: begin
        if (cmd.sel_pol) begin
          st_r <= sin_q;
          ct_r <= cos_q;
        end else begin
          sp_r <= sin_q;
          cp_r <= cos_q;
        end
      end
      default: ;
    endcase

    if (cmd.out_load) begin
      out_r <= {sat_out(SUM_W'(tz_r)), sat_out(SUM_W'(ty_r)), sat_out(SUM_W'(tx_r)),
                ez_r, ey_r, ex_r};
    end
  end

endmodule

>>> sv/ocam_ctrl.sv
`timescale 1ns / 1ps

module ocam_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  ocam_pkg::ocam_stat_t stat,
  output ocam_pkg::ocam_cmd_t  cmd
);
  import ocam_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ORB, S_ORB1, S_ORB2, S_MOD, S_AZSET,
    S_CINIT, S_CSTEP, S_CEND, S_MICRO, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sel_r, sel_nxt;
  logic             out_valid_r, out_valid_nxt;
  uop_t             uop;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign uop        = ucode(cnt_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '{load: 1'b0, out_load: 1'b0, seq: SQ_NONE, idx: cnt_r,
                      sel_pol: sel_r, mul: MS_NONE, wb: WB_NONE};
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ORB;
        end
      end
      // orbit: two gain products, then wrap the azimuth
      S_ORB: begin
        sel_nxt = 1'b0;
        if (stat.left) begin
          cmd.mul   = MS_DX_OG;
          state_nxt = S_ORB1;
        end else begin
          state_nxt = S_CINIT;
        end
      end
      S_ORB1: begin
        cmd.wb    = WB_AZ_PREP;
        cmd.mul   = MS_DY_OG;
        state_nxt = S_ORB2;
      end
      S_ORB2: begin
        cmd.wb    = WB_POL;
        cmd.mul   = MS_REM_RCP;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mul   = MS_QT_MOD;
        state_nxt = S_AZSET;
      end
      S_AZSET: begin
        cmd.seq   = SQ_AZ_SET;
        state_nxt = S_CINIT;
      end
      // sine/cosine of azimuth, then of polar
      S_CINIT: begin
        cmd.seq   = SQ_COR_INIT;
        cnt_nxt   = '0;
        state_nxt = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.seq = SQ_COR_STEP;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = S_CEND;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_CEND: begin
        cmd.seq = SQ_COR_END;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_CINIT;
        end else begin
          state_nxt = S_MICRO;
          if (stat.pan_en) cnt_nxt = UC_PAN_FIRST;
          else if (stat.zoom_en) cnt_nxt = UC_ZOOM_FIRST;
          else cnt_nxt = UC_EYE_FIRST;
        end
      end
      // pan, zoom and eye products through the shared multiplier
      S_MICRO: begin
        cmd.mul = uop.mul;
        cmd.wb  = uop.wb;
        if (cnt_r == UC_PAN_LAST) begin
          cnt_nxt = stat.zoom_en ? UC_ZOOM_FIRST : UC_EYE_FIRST;
        end else if (cnt_r == UC_EYE_LAST) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
